// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the responder.
// Depends on nothing; the checker takes this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every clock edge outside reset.
`define OBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property checked at every clock edge, reset included.
`define OBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/obd_pkg.sv -----
// Types and constants of the OBD-II service responder.
// Used by the front, the operation queue, the back and the top level.
package obd_pkg;

  localparam logic [1:0] CMD_REQ  = 2'd0;
  localparam logic [1:0] CMD_UPD  = 2'd1;
  localparam logic [1:0] CMD_SLOT = 2'd2;

  localparam logic [7:0] MODE_CUR = 8'h01;
  localparam logic [7:0] MODE_DTC = 8'h03;
  localparam logic [7:0] MODE_CLR = 8'h04;

  localparam logic [7:0] PID_MASK_ID = 8'h00;
  localparam logic [7:0] PID_LOAD    = 8'h04;
  localparam logic [7:0] PID_COOL    = 8'h05;
  localparam logic [7:0] PID_RPM     = 8'h0C;
  localparam logic [7:0] PID_SPEED   = 8'h0D;
  localparam logic [7:0] PID_THR     = 8'h11;

  localparam logic [7:0] POS_OFFSET  = 8'h40;
  localparam logic [7:0] NEG_REPLY   = 8'h7F;
  localparam logic [7:0] NRC_SERVICE = 8'h11;
  localparam logic [7:0] NRC_SUBFUNC = 8'h12;
  localparam logic [7:0] COOL_OFFSET = 8'd40;

  localparam logic [7:0] PID_MASK_BYTES [4] = '{8'hBE, 8'h3E, 8'hB8, 8'h11};

  localparam logic [3:0] LEN_MASK  = 4'd6;
  localparam logic [3:0] LEN_RPM   = 4'd4;
  localparam logic [3:0] LEN_ONE   = 4'd3;
  localparam logic [3:0] LEN_NEG   = 4'd3;
  localparam logic [3:0] LEN_CLEAR = 4'd1;
  localparam int         LIST_MAX  = 4;

  // floor(x*255/1000) is floor(floor(x*51/8)/25); the division by 25 is a
  // multiplication by a rounded-up reciprocal, exact for all 10-bit x.
  localparam int          PRE_W       = 13;
  localparam logic [5:0]  SCALE_MUL   = 6'd51;
  localparam logic [15:0] RECIP       = 16'd41944;
  localparam int          RECIP_SHIFT = 20;
  localparam int          PROD_W      = PRE_W + 16;

  localparam logic [15:0] RPM_RESET   = 16'd9800;
  localparam logic [7:0]  SPEED_RESET = 8'd68;
  localparam logic [8:0]  COOL_RESET  = 9'd88;
  localparam logic [7:0]  THR_RESET   = 8'd57;
  localparam logic [7:0]  LOAD_RESET  = 8'd86;
  localparam logic [7:0]  COUNT_RESET = 8'd1;
  localparam logic [15:0] SLOT0_RESET = 16'h0301;

  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_AW    = 1;
  localparam int OPQ_CW    = 2;

  typedef enum logic [3:0] {
    OP_UPDATE,
    OP_SLOT,
    OP_PID_MASK,
    OP_RPM,
    OP_SPEED,
    OP_COOL,
    OP_THR,
    OP_LOAD,
    OP_BAD_PID,
    OP_LIST,
    OP_CLEAR,
    OP_BAD_MODE
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [7:0]        mode;
    logic [7:0]        pid;
    logic [15:0]       rpm;
    logic [7:0]        speed;
    logic [8:0]        cool;
    logic [PRE_W-1:0]  thr_pre;
    logic [PRE_W-1:0]  load_pre;
    logic [7:0]        count;
    logic [1:0]        slot_idx;
    logic [15:0]       slot_code;
  } op_t;

endpackage

// ----- sv/obd_front.sv -----
// Front end: accepts command beats, drops those without effect, classifies
// requests and prescales live values into queue operations. Uses obd_pkg.
module obd_front (
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [1:0]             in_cmd,
  input  logic [7:0]             in_req_length,
  input  logic [7:0]             in_req_mode,
  input  logic [7:0]             in_req_pid,
  input  logic [15:0]            in_rpm_quarter,
  input  logic [7:0]             in_speed_kmh,
  input  logic signed [8:0]      in_coolant_c,
  input  logic [9:0]             in_throttle_tenths,
  input  logic [9:0]             in_load_tenths,
  input  logic [7:0]             in_code_count,
  input  logic [1:0]             in_slot_index,
  input  logic [15:0]            in_slot_code,
  input  logic                   q_full,
  output logic                   q_push,
  output obd_pkg::op_t           q_op
);
  import obd_pkg::*;

  logic keep;
  logic [15:0] thr_x51;
  logic [15:0] load_x51;

  assign in_full  = q_full;
  assign thr_x51  = 16'(in_throttle_tenths) * 16'(SCALE_MUL);
  assign load_x51 = 16'(in_load_tenths) * 16'(SCALE_MUL);

  always_comb begin
    keep             = 1'b0;
    q_op.kind        = OP_BAD_MODE;
    q_op.mode        = in_req_mode;
    q_op.pid         = in_req_pid;
    q_op.rpm         = in_rpm_quarter;
    q_op.speed       = in_speed_kmh;
    q_op.cool        = $unsigned(in_coolant_c);
    q_op.thr_pre     = thr_x51[15:3];
    q_op.load_pre    = load_x51[15:3];
    q_op.count       = in_code_count;
    q_op.slot_idx    = in_slot_index;
    q_op.slot_code   = in_slot_code;
    case (in_cmd)
      CMD_UPD: begin
        keep      = 1'b1;
        q_op.kind = OP_UPDATE;
      end
      CMD_SLOT: begin
        keep      = 1'b1;
        q_op.kind = OP_SLOT;
      end
      CMD_REQ: begin
        if (in_req_length != 8'd0) begin
          case (in_req_mode)
            MODE_CUR: begin
              keep = (in_req_length >= 8'd2);
              case (in_req_pid)
                PID_MASK_ID: q_op.kind = OP_PID_MASK;
                PID_RPM:     q_op.kind = OP_RPM;
                PID_SPEED:   q_op.kind = OP_SPEED;
                PID_COOL:    q_op.kind = OP_COOL;
                PID_THR:     q_op.kind = OP_THR;
                PID_LOAD:    q_op.kind = OP_LOAD;
                default:     q_op.kind = OP_BAD_PID;
              endcase
            end
            MODE_DTC: begin
              keep      = 1'b1;
              q_op.kind = OP_LIST;
            end
            MODE_CLR: begin
              keep      = 1'b1;
              q_op.kind = OP_CLEAR;
            end
            default: begin
              keep      = 1'b1;
              q_op.kind = OP_BAD_MODE;
            end
          endcase
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_push && !q_full && keep;

endmodule

// ----- sv/obd_opq.sv -----
// Short operation queue between the front and the back.
// Register based, first in first out; uses obd_pkg.
module obd_opq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  obd_pkg::op_t wr_op,
  output logic         full,
  input  logic         rd_en,
  output obd_pkg::op_t rd_op,
  output logic         empty
);
  import obd_pkg::*;

  op_t              mem_r [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr_r;
  logic [OPQ_AW-1:0] wr_ptr_nxt;
  logic [OPQ_AW-1:0] rd_ptr_r;
  logic [OPQ_AW-1:0] rd_ptr_nxt;
  logic [OPQ_CW-1:0] cnt_r;
  logic [OPQ_CW-1:0] cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full  = (cnt_r == OPQ_CW'(OPQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_op = mem_r[rd_ptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? OPQ_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? OPQ_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = OPQ_CW'(cnt_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = OPQ_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

// ----- sv/obd_back.sv -----
// Back end: holds the vehicle snapshot, carries out queued operations and
// streams reply bytes through an output register. Uses obd_pkg.
module obd_back #(
  parameter int CODE_SLOTS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  obd_pkg::op_t q_op,
  output logic         q_pop,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [7:0]   out_resp_byte,
  output logic         out_resp_last
);
  import obd_pkg::*;

  localparam int SW     = (CODE_SLOTS > 1) ? $clog2(CODE_SLOTS) : 1;
  localparam int LIST_N = (CODE_SLOTS < LIST_MAX) ? CODE_SLOTS : LIST_MAX;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t      state_r,    state_nxt;
  op_t         cur_r,      cur_nxt;
  logic [3:0]  len_r,      len_nxt;
  logic [3:0]  idx_r,      idx_nxt;
  logic [15:0] rpm_r,      rpm_nxt;
  logic [7:0]  spd_r,      spd_nxt;
  logic [8:0]  cool_r,     cool_nxt;
  logic [7:0]  thr_r,      thr_nxt;
  logic [7:0]  load_r,     load_nxt;
  logic [7:0]  cnt_r,      cnt_nxt;
  logic [15:0] slots_r   [CODE_SLOTS];
  logic [15:0] slots_nxt [CODE_SLOTS];
  logic        out_vld_r,  out_vld_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic              can_emit;
  logic [PROD_W-1:0] thr_prod;
  logic [PROD_W-1:0] load_prod;
  logic [8:0]        thr_q;
  logic [8:0]        load_q;
  logic [2:0]        list_n;
  logic [3:0]        code_pos;
  logic [2:0]        slot_k;
  logic [15:0]       code_word;
  logic [SW-1:0]     wr_idx;
  logic [7:0]        gen_byte;

  assign out_empty     = !out_vld_r;
  assign out_resp_byte = out_byte_r;
  assign out_resp_last = out_last_r;
  assign can_emit      = !out_vld_r || out_pop;
  assign q_pop         = (state_r == ST_IDLE) && !q_empty;

  assign thr_prod  = PROD_W'(q_op.thr_pre) * PROD_W'(RECIP);
  assign load_prod = PROD_W'(q_op.load_pre) * PROD_W'(RECIP);
  assign thr_q     = thr_prod[RECIP_SHIFT +: 9];
  assign load_q    = load_prod[RECIP_SHIFT +: 9];
  assign list_n    = (cnt_r < 8'(LIST_N)) ? 3'(cnt_r) : 3'(LIST_N);
  assign wr_idx    = SW'(q_op.slot_idx);

  assign code_pos  = 4'(idx_r - 4'd2);
  assign slot_k    = code_pos[3:1];
  assign code_word = (32'(slot_k) < CODE_SLOTS) ? slots_r[SW'(slot_k)] : 16'h0000;

  always_comb begin
    gen_byte = 8'h00;
    case (cur_r.kind)
      OP_PID_MASK, OP_RPM, OP_SPEED, OP_COOL, OP_THR, OP_LOAD: begin
        if (idx_r == 4'd0) begin
          gen_byte = 8'(MODE_CUR + POS_OFFSET);
        end else if (idx_r == 4'd1) begin
          gen_byte = cur_r.pid;
        end else begin
          case (cur_r.kind)
            OP_PID_MASK: gen_byte = PID_MASK_BYTES[code_pos[1:0]];
            OP_RPM:      gen_byte = code_pos[0] ? rpm_r[7:0] : rpm_r[15:8];
            OP_SPEED:    gen_byte = spd_r;
            OP_COOL:     gen_byte = 8'(cool_r[7:0] + COOL_OFFSET);
            OP_THR:      gen_byte = thr_r;
            OP_LOAD:     gen_byte = load_r;
            default:     gen_byte = 8'h00;
          endcase
        end
      end
      OP_LIST: begin
        if (idx_r == 4'd0) begin
          gen_byte = 8'(MODE_DTC + POS_OFFSET);
        end else if (idx_r == 4'd1) begin
          gen_byte = cnt_r;
        end else begin
          gen_byte = code_pos[0] ? code_word[7:0] : code_word[15:8];
        end
      end
      OP_CLEAR: gen_byte = 8'(MODE_CLR + POS_OFFSET);
      OP_BAD_PID, OP_BAD_MODE: begin
        if (idx_r == 4'd0) begin
          gen_byte = NEG_REPLY;
        end else if (idx_r == 4'd1) begin
          gen_byte = cur_r.mode;
        end else begin
          gen_byte = (cur_r.kind == OP_BAD_PID) ? NRC_SUBFUNC : NRC_SERVICE;
        end
      end
      default: gen_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    rpm_nxt      = rpm_r;
    spd_nxt      = spd_r;
    cool_nxt     = cool_r;
    thr_nxt      = thr_r;
    load_nxt     = load_r;
    cnt_nxt      = cnt_r;
    slots_nxt    = slots_r;
    out_vld_nxt  = out_vld_r && !out_pop;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          cur_nxt = q_op;
          idx_nxt = 4'd0;
          case (q_op.kind)
            OP_UPDATE: begin
              rpm_nxt  = q_op.rpm;
              spd_nxt  = q_op.speed;
              cool_nxt = q_op.cool;
              thr_nxt  = thr_q[8] ? 8'hFF : thr_q[7:0];
              load_nxt = load_q[8] ? 8'hFF : load_q[7:0];
              cnt_nxt  = q_op.count;
            end
            OP_SLOT: begin
              if (32'(q_op.slot_idx) < CODE_SLOTS) begin
                slots_nxt[wr_idx] = q_op.slot_code;
              end
            end
            OP_PID_MASK: begin
              len_nxt   = LEN_MASK;
              state_nxt = ST_EMIT;
            end
            OP_RPM: begin
              len_nxt   = LEN_RPM;
              state_nxt = ST_EMIT;
            end
            OP_SPEED, OP_COOL, OP_THR, OP_LOAD: begin
              len_nxt   = LEN_ONE;
              state_nxt = ST_EMIT;
            end
            OP_LIST: begin
              len_nxt   = 4'(4'd2 + {list_n, 1'b0});
              state_nxt = ST_EMIT;
            end
            OP_CLEAR: begin
              cnt_nxt   = 8'd0;
              len_nxt   = LEN_CLEAR;
              state_nxt = ST_EMIT;
            end
            default: begin
              len_nxt   = LEN_NEG;
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          out_vld_nxt  = 1'b1;
          out_byte_nxt = gen_byte;
          out_last_nxt = (idx_r == 4'(len_r - 4'd1));
          idx_nxt      = 4'(idx_r + 4'd1);
          if (idx_r == 4'(len_r - 4'd1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      rpm_r     <= RPM_RESET;
      spd_r     <= SPEED_RESET;
      cool_r    <= COOL_RESET;
      thr_r     <= THR_RESET;
      load_r    <= LOAD_RESET;
      cnt_r     <= COUNT_RESET;
      for (int i = 0; i < CODE_SLOTS; i++) begin
        slots_r[i] <= (i == 0) ? SLOT0_RESET : 16'h0000;
      end
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      rpm_r     <= rpm_nxt;
      spd_r     <= spd_nxt;
      cool_r    <= cool_nxt;
      thr_r     <= thr_nxt;
      load_r    <= load_nxt;
      cnt_r     <= cnt_nxt;
      slots_r   <= slots_nxt;
    end
    cur_r      <= cur_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ----- sv/obd2_service_responder.sv -----
// Top level of the OBD-II service responder.
// Instantiates obd_front, obd_opq and obd_back; uses obd_pkg.
//
// The block takes one command beat per cycle while full is low: live-value
// updates and code-slot writes are applied by the back end as it pops
// them, and a request is issued and then emits its reply bytes in order;
// a listing of four codes at two bytes per code is the longest reply.
// The back end emits one reply byte per cycle into its output register
// while that register is empty or popped; a two-entry queue lets the front
// keep accepting while the back works or reply beats wait on pop.
// Requests of length zero, short mode 0x01 requests and unused commands are
// dropped at the front and cost nothing downstream.
module obd2_service_responder #(
  parameter int CODE_SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_req_length,
  input  logic [7:0]        in_req_mode,
  input  logic [7:0]        in_req_pid,
  input  logic [15:0]       in_rpm_quarter,
  input  logic [7:0]        in_speed_kmh,
  input  logic signed [8:0] in_coolant_c,
  input  logic [9:0]        in_throttle_tenths,
  input  logic [9:0]        in_load_tenths,
  input  logic [7:0]        in_code_count,
  input  logic [1:0]        in_slot_index,
  input  logic [15:0]       in_slot_code,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_resp_byte,
  output logic              out_resp_last
);
  import obd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_empty;
  logic q_pop;
  op_t  push_op;
  op_t  head_op;

  obd_front u_front (
    .in_push            (in_push),
    .in_full            (in_full),
    .in_cmd             (in_cmd),
    .in_req_length      (in_req_length),
    .in_req_mode        (in_req_mode),
    .in_req_pid         (in_req_pid),
    .in_rpm_quarter     (in_rpm_quarter),
    .in_speed_kmh       (in_speed_kmh),
    .in_coolant_c       (in_coolant_c),
    .in_throttle_tenths (in_throttle_tenths),
    .in_load_tenths     (in_load_tenths),
    .in_code_count      (in_code_count),
    .in_slot_index      (in_slot_index),
    .in_slot_code       (in_slot_code),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_op               (push_op)
  );

  obd_opq u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .wr_op (push_op),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_op (head_op),
    .empty (q_empty)
  );

  obd_back #(
    .CODE_SLOTS (CODE_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_op          (head_op),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_resp_byte (out_resp_byte),
    .out_resp_last (out_resp_last)
  );

endmodule

// ----- sv/obd_chk.sv -----
// Port-level checker for the OBD-II service responder, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module obd_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic [7:0]        out_resp_byte,
  input logic              out_resp_last
);

  logic       beat_take;
  logic       beat_wait;
  logic [8:0] out_beat;

  assign beat_take = !out_empty && out_pop;
  assign beat_wait = !out_empty && !out_pop;
  assign out_beat  = {out_resp_byte, out_resp_last};

  // Reset leaves no reply beat waiting and the command side open.
  `OBD_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> out_empty, "result after reset")
  `OBD_ASSERT_ALWAYS(a_rst_open, clk, !rst_n |=> !in_full, "full after reset")

  // A reply streams without gaps once its first beat has been taken.
  `OBD_ASSERT(a_no_gap, clk, rst_n, beat_take && !out_resp_last |=> !out_empty, "gap in a reply")

  // A waiting beat that is not popped stays as it is.
  `OBD_ASSERT(a_hold_vld, clk, rst_n, beat_wait |=> !out_empty, "waiting beat lost")
  `OBD_ASSERT(a_hold_data, clk, rst_n, beat_wait |=> $stable(out_beat), "waiting beat changed")

endmodule

bind obd2_service_responder obd_chk u_obd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_resp_byte (out_resp_byte),
  .out_resp_last (out_resp_last)
);

// ----- bench/obd2_service_responder_test.sv -----
// Self-checking testbench for obd2_service_responder: a directed table, then random commands.
// Replies are predicted by a snapshot model kept here and checked beat by beat.
// Depends on obd_pkg and the responder RTL only.
module obd2_service_responder_test;
  import obd_pkg::*;

  localparam int SLOT_COUNT = 4;
  localparam int RANDOM_ITEMS = 224;

  localparam logic [1:0] CMD_IDLE = 2'd3;
  localparam logic [7:0] REPLY_CUR = MODE_CUR + POS_OFFSET;
  localparam logic [7:0] REPLY_DTC = MODE_DTC + POS_OFFSET;
  localparam logic [7:0] REPLY_CLR = MODE_CLR + POS_OFFSET;
  localparam logic [7:0] PID_UNKNOWN = 8'h20;
  localparam logic [7:0] MODE_UNKNOWN = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  len;
    logic [7:0]  mode;
    logic [7:0]  pid;
    logic [15:0] rpm;
    logic [7:0]  speed;
    logic [8:0]  cool;
    logic [9:0]  thr;
    logic [9:0]  load;
    logic [7:0]  count;
    logic [1:0]  idx;
    logic [15:0] code;
  } command_t;

  localparam int CMD_W = $bits(command_t);

  typedef struct packed {
    command_t    c;
    logic        typed;
    logic [3:0]  n;
    logic [79:0] bytes;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [1:0]        in_cmd;
  logic [7:0]        in_req_length;
  logic [7:0]        in_req_mode;
  logic [7:0]        in_req_pid;
  logic [15:0]       in_rpm_quarter;
  logic [7:0]        in_speed_kmh;
  logic signed [8:0] in_coolant_c;
  logic [9:0]        in_throttle_tenths;
  logic [9:0]        in_load_tenths;
  logic [7:0]        in_code_count;
  logic [1:0]        in_slot_index;
  logic [15:0]       in_slot_code;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [7:0]        out_resp_byte;
  logic              out_resp_last;

  logic [15:0] snap_rpm;
  logic [7:0]  snap_speed;
  logic [8:0]  snap_cool;
  logic [9:0]  snap_thr;
  logic [9:0]  snap_load;
  logic [7:0]  snap_count;
  logic [15:0] snap_slots [SLOT_COUNT];

  reply_beat_t reply_q [$];
  reply_beat_t want;
  stim_row_t   directed_rows [$];
  command_t    rnd_cmd;
  int          fail_count = 0;
  int          burst_left = 1;
  int          sent_items;
  logic [15:0] pop_pattern = '1;
  int          pop_cycle = 0;

  obd2_service_responder #(
    .CODE_SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_cmd             (in_cmd),
    .in_req_length      (in_req_length),
    .in_req_mode        (in_req_mode),
    .in_req_pid         (in_req_pid),
    .in_rpm_quarter     (in_rpm_quarter),
    .in_speed_kmh       (in_speed_kmh),
    .in_coolant_c       (in_coolant_c),
    .in_throttle_tenths (in_throttle_tenths),
    .in_load_tenths     (in_load_tenths),
    .in_code_count      (in_code_count),
    .in_slot_index      (in_slot_index),
    .in_slot_code       (in_slot_code),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_resp_byte      (out_resp_byte),
    .out_resp_last      (out_resp_last)
  );

  always #10 clk = ~clk;

  function automatic command_t req_cmd(logic [7:0] len, logic [7:0] mode, logic [7:0] pid);
    command_t c;
    c = '0;
    c.cmd = CMD_REQ;
    c.len = len;
    c.mode = mode;
    c.pid = pid;
    return c;
  endfunction

  function automatic command_t update_cmd(logic [15:0] rpm, logic [7:0] speed, logic [8:0] cool,
                                          logic [9:0] thr, logic [9:0] load, logic [7:0] count);
    command_t c;
    c = '0;
    c.cmd = CMD_UPD;
    c.rpm = rpm;
    c.speed = speed;
    c.cool = cool;
    c.thr = thr;
    c.load = load;
    c.count = count;
    return c;
  endfunction

  function automatic command_t slot_cmd(logic [1:0] idx, logic [15:0] code);
    command_t c;
    c = '0;
    c.cmd = CMD_SLOT;
    c.idx = idx;
    c.code = code;
    return c;
  endfunction

  function automatic bit is_dropped(command_t c);
    return c.cmd == CMD_IDLE ||
           (c.cmd == CMD_REQ && (c.len == 8'd0 || (c.mode == MODE_CUR && c.len < 8'd2)));
  endfunction

  function automatic logic [7:0] tenths_to_byte(logic [9:0] x);
    int v;
    v = int'(x) * 255 / 1000;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // Applies one command to the snapshot and returns the reply it causes.
  function automatic void answer_command(input command_t c, output logic [7:0] bytes [$]);
    int i;
    bytes = {};
    if (c.cmd == CMD_UPD) begin
      snap_rpm = c.rpm;
      snap_speed = c.speed;
      snap_cool = c.cool;
      snap_thr = c.thr;
      snap_load = c.load;
      snap_count = c.count;
    end else if (c.cmd == CMD_SLOT) begin
      if (c.idx < SLOT_COUNT) snap_slots[c.idx] = c.code;
    end else if (c.cmd == CMD_REQ && !is_dropped(c)) begin
      if (c.mode == MODE_CUR) begin
        bytes = '{REPLY_CUR, c.pid};
        case (c.pid)
          PID_MASK_ID: begin
            for (i = 0; i < 4; i++) bytes.push_back(PID_MASK_BYTES[i]);
          end
          PID_RPM: begin
            bytes.push_back(snap_rpm[15:8]);
            bytes.push_back(snap_rpm[7:0]);
          end
          PID_SPEED: bytes.push_back(snap_speed);
          PID_COOL: bytes.push_back(8'(snap_cool[7:0] + COOL_OFFSET));
          PID_THR: bytes.push_back(tenths_to_byte(snap_thr));
          PID_LOAD: bytes.push_back(tenths_to_byte(snap_load));
          default: bytes = '{NEG_REPLY, c.mode, NRC_SUBFUNC};
        endcase
      end else if (c.mode == MODE_DTC) begin
        bytes = '{REPLY_DTC, snap_count};
        for (i = 0; i < LIST_MAX && i < SLOT_COUNT && i < int'(snap_count); i++) begin
          bytes.push_back(snap_slots[i][15:8]);
          bytes.push_back(snap_slots[i][7:0]);
        end
      end else if (c.mode == MODE_CLR) begin
        snap_count = 8'd0;
        bytes = '{REPLY_CLR};
      end else begin
        bytes = '{NEG_REPLY, c.mode, NRC_SERVICE};
      end
    end
  endfunction

  function automatic command_t random_command();
    command_t c;
    int pick;
    c = CMD_W'({$urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      c.cmd = CMD_REQ;
      pick = $urandom_range(0, 19);
      if (pick == 0) c.len = 8'd0;
      else if (pick < 3) c.len = 8'd1;
      else if (pick < 10) c.len = 8'd2;
      else c.len = 8'($urandom_range(2, 255));
      pick = $urandom_range(0, 9);
      if (pick < 5) c.mode = MODE_CUR;
      else if (pick < 7) c.mode = MODE_DTC;
      else if (pick == 7) c.mode = MODE_CLR;
      if (c.mode == MODE_CUR && $urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 5))
          0: c.pid = PID_MASK_ID;
          1: c.pid = PID_RPM;
          2: c.pid = PID_SPEED;
          3: c.pid = PID_COOL;
          4: c.pid = PID_THR;
          default: c.pid = PID_LOAD;
        endcase
      end
    end else if (pick < 75) begin
      c.cmd = CMD_UPD;
      if ($urandom_range(0, 3) != 0) c.cool = 9'($urandom_range(0, 255)) - 9'd40;
      if ($urandom_range(0, 3) != 0) c.thr = 10'($urandom_range(0, 1000));
      if ($urandom_range(0, 3) != 0) c.load = 10'($urandom_range(0, 1000));
      if ($urandom_range(0, 1) != 0) c.count = 8'($urandom_range(0, 6));
    end else if (pick < 93) begin
      c.cmd = CMD_SLOT;
    end else begin
      c.cmd = CMD_IDLE;
    end
    return c;
  endfunction

  // Holds the command on the inputs until a beat is taken, then queues its reply.
  task automatic send_command(command_t c, logic typed, logic [3:0] n, logic [79:0] vec);
    logic [7:0] bytes [$];
    reply_beat_t beat;
    int k;
    int nb;
    @(negedge clk);
    in_cmd <= c.cmd;
    in_req_length <= c.len;
    in_req_mode <= c.mode;
    in_req_pid <= c.pid;
    in_rpm_quarter <= c.rpm;
    in_speed_kmh <= c.speed;
    in_coolant_c <= c.cool;
    in_throttle_tenths <= c.thr;
    in_load_tenths <= c.load;
    in_code_count <= c.count;
    in_slot_index <= c.idx;
    in_slot_code <= c.code;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    answer_command(c, bytes);
    if (typed) begin
      nb = n;
      bytes = {};
      for (k = 0; k < nb; k++) bytes.push_back(vec[(nb - 1 - k) * 8 +: 8]);
    end
    for (k = 0; k < bytes.size(); k++) begin
      beat.data = bytes[k];
      beat.last = (k == bytes.size() - 1);
      reply_q.push_back(beat);
    end
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  always @(negedge clk) begin
    if (pop_cycle == 0) begin
      pop_cycle = $urandom_range(16, 80);
      case ($urandom_range(0, 3))
        0: pop_pattern = '1;
        1: pop_pattern = 16'($urandom);
        2: pop_pattern = 16'($urandom & $urandom);
        default: pop_pattern = 16'(~($urandom & $urandom));
      endcase
    end else begin
      pop_cycle = pop_cycle - 1;
      pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
    end
    out_pop <= pop_pattern[0];
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (reply_q.size() == 0) begin
        $display("%0t: reply beat %02h last %0d with none expected",
                 $time, out_resp_byte, out_resp_last);
        fail_count++;
      end else begin
        want = reply_q.pop_front();
        if (out_resp_byte !== want.data) begin
          $display("%0t: resp_byte expected %02h, got %02h", $time, want.data, out_resp_byte);
          fail_count++;
        end
        if (out_resp_last !== want.last) begin
          $display("%0t: resp_last expected %0d, got %0d", $time, want.last, out_resp_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_cmd = CMD_IDLE;
    in_req_length = '0;
    in_req_mode = '0;
    in_req_pid = '0;
    in_rpm_quarter = '0;
    in_speed_kmh = '0;
    in_coolant_c = '0;
    in_throttle_tenths = '0;
    in_load_tenths = '0;
    in_code_count = '0;
    in_slot_index = '0;
    in_slot_code = '0;

    snap_rpm = 16'd9800;
    snap_speed = 8'd68;
    snap_cool = 9'd88;
    snap_thr = 10'd224;
    snap_load = 10'd340;
    snap_count = 8'd1;
    foreach (snap_slots[i]) snap_slots[i] = '0;
    snap_slots[0] = 16'h0301;

    // Rows marked typed carry their reply; the others are checked against the snapshot.
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_MASK_ID), 1'b1, 4'd6,
                              {REPLY_CUR, PID_MASK_ID, 8'hBE, 8'h3E, 8'hB8, 8'h11}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_RPM), 1'b1, 4'd4,
                              {REPLY_CUR, PID_RPM, 8'h26, 8'h48}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_SPEED), 1'b1, 4'd3,
                              {REPLY_CUR, PID_SPEED, 8'h44}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_COOL), 1'b1, 4'd3,
                              {REPLY_CUR, PID_COOL, 8'h80}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_THR), 1'b1, 4'd3,
                              {REPLY_CUR, PID_THR, 8'h39}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_LOAD), 1'b1, 4'd3,
                              {REPLY_CUR, PID_LOAD, 8'h56}});
    directed_rows.push_back('{req_cmd(8'd1, MODE_DTC, 8'h00), 1'b1, 4'd4,
                              {REPLY_DTC, 8'h01, 8'h03, 8'h01}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_UNKNOWN), 1'b1, 4'd3,
                              {NEG_REPLY, MODE_CUR, NRC_SUBFUNC}});
    directed_rows.push_back('{req_cmd(8'd0, MODE_CUR, PID_RPM), 1'b1, 4'd0, '0});
    directed_rows.push_back('{req_cmd(8'd1, MODE_CUR, PID_RPM), 1'b1, 4'd0, '0});
    directed_rows.push_back('{'{cmd: CMD_IDLE, default: '1}, 1'b1, 4'd0, '0});
    directed_rows.push_back('{update_cmd(16'hFFFF, 8'hFF, 9'h1D8, 10'd1023, 10'd1000, 8'hFF),
                              1'b1, 4'd0, '0});
    directed_rows.push_back('{slot_cmd(2'd1, 16'h1234), 1'b1, 4'd0, '0});
    directed_rows.push_back('{slot_cmd(2'd3, 16'hFFFF), 1'b1, 4'd0, '0});
    directed_rows.push_back('{req_cmd(8'd255, MODE_DTC, 8'hFF), 1'b0, 4'd0, '0});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_THR), 1'b1, 4'd3,
                              {REPLY_CUR, PID_THR, 8'hFF}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_LOAD), 1'b1, 4'd3,
                              {REPLY_CUR, PID_LOAD, 8'hFF}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_COOL), 1'b1, 4'd3,
                              {REPLY_CUR, PID_COOL, 8'h00}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_RPM), 1'b1, 4'd4,
                              {REPLY_CUR, PID_RPM, 8'hFF, 8'hFF}});
    directed_rows.push_back('{update_cmd(16'h0000, 8'h00, 9'd215, 10'd0, 10'd0, 8'd2),
                              1'b1, 4'd0, '0});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_COOL), 1'b1, 4'd3,
                              {REPLY_CUR, PID_COOL, 8'hFF}});
    directed_rows.push_back('{update_cmd(16'h0001, 8'h01, 9'h100, 10'd1, 10'd1, 8'd3),
                              1'b0, 4'd0, '0});
    directed_rows.push_back('{req_cmd(8'd2, MODE_CUR, PID_COOL), 1'b0, 4'd0, '0});
    directed_rows.push_back('{req_cmd(8'd3, MODE_CLR, 8'h00), 1'b1, 4'd1, {REPLY_CLR}});
    directed_rows.push_back('{req_cmd(8'd2, MODE_DTC, 8'h00), 1'b1, 4'd2,
                              {REPLY_DTC, 8'h00}});
    directed_rows.push_back('{req_cmd(8'd255, MODE_UNKNOWN, 8'hFF), 1'b1, 4'd3,
                              {NEG_REPLY, MODE_UNKNOWN, NRC_SERVICE}});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_command(directed_rows[r].c, directed_rows[r].typed, directed_rows[r].n,
                   directed_rows[r].bytes);
      pace_sender();
    end

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      rnd_cmd = random_command();
      send_command(rnd_cmd, 1'b0, 4'd0, '0);
      sent_items++;
      pace_sender();
    end

    @(negedge clk);
    in_push <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
